[design/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg: shared types and defaults of the linear probing hash table
// Command and status codes of the transactions and default table geometry.
// ----------------------------------------------------------------------------
package lph_pkg;

  // default table geometry
  localparam int LPH_TABLE_SLOTS = 8;
  localparam int LPH_KEY_BITS    = 32;
  localparam int LPH_VALUE_BITS  = 32;

  // width of the key and value ports
  localparam int LPH_PORT_W = 32;

  // command codes of an input transaction
  typedef enum logic {
    CMD_SET = 1'b0,
    CMD_GET = 1'b1
  } lph_cmd_t;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } lph_status_t;

endpackage

[design/lph_home.sv]
// ----------------------------------------------------------------------------
// lph_home: home slot unit
// Reduces a key modulo the table size. A power-of-two table registers the low
// key bits; any other size computes the remainder in registered steps:
// a reciprocal multiply for the quotient, a multiply back by the table size,
// then a subtract from the key.
// ----------------------------------------------------------------------------
module lph_home #(
  parameter int TABLE_SLOTS = lph_pkg::LPH_TABLE_SLOTS,
  parameter int KEY_W       = lph_pkg::LPH_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] home
);

  localparam int  IDX_W      = $clog2(TABLE_SLOTS);
  localparam bit  SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  generate
    if (SLOTS_POW2) begin : g_pow2
      localparam int EXT_W = (KEY_W > IDX_W) ? KEY_W : IDX_W;

      logic [EXT_W-1:0] key_ext;
      logic [IDX_W-1:0] home_r;
      logic             done_r;

      assign key_ext = EXT_W'(key);

      // low key bits are the home slot
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          home_r <= key_ext[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_recip
      // quotient by multiply with ceil(2^SHIFT / TABLE_SLOTS), exact for all keys
      localparam int                 EXT_W    = (KEY_W > IDX_W) ? KEY_W : IDX_W;
      localparam int                 SHIFT    = KEY_W + IDX_W;
      localparam int                 MAG_W    = KEY_W + 2;
      localparam int                 PROD_W   = SHIFT + KEY_W;
      localparam logic [63:0]        MAG_FULL = ((64'd1 << SHIFT) / 64'(TABLE_SLOTS)) + 64'd1;
      localparam logic [MAG_W-1:0]   MAGIC    = MAG_FULL[MAG_W-1:0];
      localparam logic [SHIFT-1:0]   SLOTS_W  = SHIFT'(TABLE_SLOTS);

      logic              v1_r;
      logic              v2_r;
      logic              done_r;
      logic [KEY_W-1:0]  key1_r;
      logic [PROD_W-1:0] prod_r;
      logic [KEY_W-1:0]  key2_r;
      logic [KEY_W-1:0]  qn_r;
      logic [IDX_W-1:0]  rem_r;
      logic [PROD_W-1:0] prod_nxt;
      logic [SHIFT-1:0]  qn_prod;
      logic [EXT_W-1:0]  diff;

      // quotient estimate, quotient times table size, remainder
      always_comb begin
        prod_nxt = PROD_W'(key) * PROD_W'(MAGIC);
        qn_prod  = SHIFT'(prod_r[SHIFT +: KEY_W]) * SLOTS_W;
        diff     = EXT_W'(key2_r) - EXT_W'(qn_r);
      end

      // three steps, each one registered
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          v2_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          v2_r   <= v1_r;
          done_r <= v2_r;
        end
        if (start) begin
          key1_r <= key;
          prod_r <= prod_nxt;
        end
        if (v1_r) begin
          key2_r <= key1_r;
          qn_r   <= qn_prod[KEY_W-1:0];
        end
        if (v2_r) begin
          rem_r <= diff[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign home = rem_r;
    end
  endgenerate

endmodule

[design/lph_mem.sv]
// ----------------------------------------------------------------------------
// lph_mem: slot memory
// One write port and one read port, read data registered. Each word holds
// the used flag, the key and the value of one slot.
// ----------------------------------------------------------------------------
module lph_mem #(
  parameter int DEPTH  = lph_pkg::LPH_TABLE_SLOTS,
  parameter int DATA_W = 1 + lph_pkg::LPH_KEY_BITS + lph_pkg::LPH_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/linear_probe_hash_table_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open addressing key/value table
// Set and get commands over a linear probing table held in one slot memory,
// walked one slot per cycle by a single key compare under a sequencer.
// ----------------------------------------------------------------------------
// sequence: S_HOME waits for the home slot unit, S_PROBE walks the slots from the
//   home slot until the command is decided or every slot has been probed, and S_FIN
//   loads the registered result once the output register is free
// transactions: one at a time; the next is accepted the cycle after the result is
//   loaded
// reset: a clearing pass empties every slot, in_ready low
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int TABLE_SLOTS = lph_pkg::LPH_TABLE_SLOTS,
  parameter int KEY_BITS    = lph_pkg::LPH_KEY_BITS,
  parameter int VALUE_BITS  = lph_pkg::LPH_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [lph_pkg::LPH_PORT_W-1:0]  in_lookup_key,
  input  logic [lph_pkg::LPH_PORT_W-1:0]  in_new_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [lph_pkg::LPH_PORT_W-1:0]  out_found_value
);

  import lph_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = (KEY_BITS < LPH_PORT_W) ? KEY_BITS : LPH_PORT_W;
  localparam int VAL_W  = (VALUE_BITS < LPH_PORT_W) ? VALUE_BITS : LPH_PORT_W;
  localparam int DATA_W = 1 + KEY_W + VAL_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  probe_cnt_r, probe_cnt_nxt;
  lph_cmd_t          cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  lph_status_t       res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              out_valid_r, out_valid_nxt;
  lph_status_t       out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;

  logic              accept;
  logic [KEY_W-1:0]  key_in;
  logic              home_done;
  logic [IDX_W-1:0]  home_slot;
  logic [IDX_W-1:0]  pos_inc;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;
  logic              slot_used;
  logic [KEY_W-1:0]  slot_key;
  logic [VAL_W-1:0]  slot_value;
  logic              key_hit;
  logic              out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign key_in   = in_lookup_key[KEY_W-1:0];

  // home slot of the incoming key
  lph_home #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_W       (KEY_W)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (key_in),
    .done  (home_done),
    .home  (home_slot)
  );

  // slot storage
  lph_mem #(
    .DEPTH  (TABLE_SLOTS),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // fields of the slot read in the previous cycle
  assign slot_used  = mem_rd_data[DATA_W-1];
  assign slot_key   = mem_rd_data[VAL_W +: KEY_W];
  assign slot_value = mem_rd_data[VAL_W-1:0];
  assign key_hit    = slot_used && (slot_key == key_r);

  // next probe position, wrapping at the table end
  assign pos_inc     = (pos_r == IDX_LAST) ? '0 : (pos_r + 1'b1);
  assign mem_rd_addr = (state_r == S_HOME) ? home_slot : pos_inc;

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    pos_nxt        = pos_r;
    probe_cnt_nxt  = probe_cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = pos_r;
    mem_wr_data    = {1'b1, key_r, val_r};

    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = lph_cmd_t'(in_command);
          key_nxt   = key_in;
          val_nxt   = in_new_value[VAL_W-1:0];
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        if (home_done) begin
          pos_nxt       = home_slot;
          probe_cnt_nxt = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        res_value_nxt = '0;
        if (cmd_r == CMD_SET) begin
          if (!slot_used || key_hit) begin
            mem_wr_en      = 1'b1;
            res_status_nxt = ST_STORED;
            state_nxt      = S_FIN;
          end else if (probe_cnt_r == IDX_LAST) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_FIN;
          end
        end else begin
          if (!slot_used) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_FIN;
          end else if (key_hit) begin
            res_status_nxt = ST_FOUND;
            res_value_nxt  = slot_value;
            state_nxt      = S_FIN;
          end else if (probe_cnt_r == IDX_LAST) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_FIN;
          end
        end
        pos_nxt       = pos_inc;
        probe_cnt_nxt = probe_cnt_r + 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = LPH_PORT_W'(out_value_r);

endmodule

[design/lph_checker.sv]
// ----------------------------------------------------------------------------
// lph_checker: port checks of the hash table core
// Watches the transaction ports and flags results that do not fit the
// command that was accepted; bound to the core module below.
// ----------------------------------------------------------------------------
module lph_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_command,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_status,
  input logic [lph_pkg::LPH_PORT_W-1:0] out_found_value
);

  import lph_pkg::*;

  logic       push;
  logic       pop;
  logic [1:0] cnt_r, cnt_nxt;
  logic       head_cmd_r, head_cmd_nxt;
  logic       tail_cmd_r, tail_cmd_nxt;

  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // commands of transactions still owed a result, oldest at the head
  always_comb begin
    cnt_nxt      = cnt_r + 2'(push) - 2'(pop);
    head_cmd_nxt = head_cmd_r;
    tail_cmd_nxt = tail_cmd_r;
    if (pop) begin
      head_cmd_nxt = tail_cmd_r;
    end
    if (push) begin
      if ((cnt_r == 2'd0) || (pop && (cnt_r == 2'd1))) begin
        head_cmd_nxt = in_command;
      end else begin
        tail_cmd_nxt = in_command;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_cmd_r <= head_cmd_nxt;
    tail_cmd_r <= tail_cmd_nxt;
  end

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // a result that is not a hit carries a zero value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_FOUND)) |-> (out_found_value == '0))
    else $error("nonzero value on a result that is not found");

  // a set reports stored or full
  a_set_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (head_cmd_r == CMD_SET)) |->
      ((out_status == ST_STORED) || (out_status == ST_FULL)))
    else $error("set returned a lookup status");

  // a get reports found or not found
  a_get_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (head_cmd_r == CMD_GET)) |->
      ((out_status == ST_FOUND) || (out_status == ST_NOT_FOUND)))
    else $error("get returned a store status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_found_value)))
    else $error("result changed while stalled");

endmodule

bind linear_probe_hash_table_core lph_checker u_lph_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found_value (out_found_value)
);
